// ===== design/rmq_pkg.sv =====
// shared constants, types and helpers for the rotation matrix to quaternion block
// no dependencies
`default_nettype none
package rmq_pkg;
    localparam int FRAC_BITS  = 14;
    localparam int DATA_W     = 16;
    localparam int THR_W      = 15;
    localparam int TRACE_W    = DATA_W + 2;
    localparam int RAD_W      = DATA_W + 3;
    localparam int D_W        = DATA_W + 1;
    localparam int SQ_IN_W    = 31;
    localparam int SQ_RES_W   = 32;
    localparam int SQ_STAGES  = 16;
    localparam int S_W        = 16;
    localparam int DEN_W      = S_W + 1;
    localparam int NUM_W      = 31;
    localparam int QUO_W      = 23;
    localparam int CMP_W      = NUM_W + QUO_W;
    localparam int LANES      = 3;

    localparam logic [1:0] ROOT_X = 2'd0;
    localparam logic [1:0] ROOT_Y = 2'd1;
    localparam logic [1:0] ROOT_Z = 2'd2;
    localparam logic [1:0] ROOT_W = 2'd3;

    typedef struct packed {
        logic                  degen;
        logic [1:0]            root;
        logic signed [D_W-1:0] d0;
        logic signed [D_W-1:0] d1;
        logic signed [D_W-1:0] d2;
    } t_side;

    function automatic logic signed [DATA_W-1:0] sat_mag(input logic [QUO_W-1:0] mag,
                                                         input logic neg);
        logic signed [DATA_W-1:0] res;
        if (neg) begin
            if (mag > QUO_W'(32768)) begin
                res = 16'sh8000;
            end else begin
                res = DATA_W'(-$signed({1'b0, mag}));
            end
        end else begin
            if (mag > QUO_W'(32767)) begin
                res = 16'sh7fff;
            end else begin
                res = DATA_W'(mag);
            end
        end
        return res;
    endfunction
endpackage
`default_nettype wire

// ===== design/rotation_matrix_to_quaternion_top.sv =====
// rotation matrix to quaternion converter, top level with config register and output stage
// depends on rmq_pkg, rmq_front, rmq_sqrt, rmq_div
//
// channel   direction  handshake            payload
// matrix    in         i_valid / o_stall    i_m00 .. i_m22
// quat      out        o_valid / i_stall    o_quat_x/y/z/w, o_degenerate
// config    in         apb psel/penable     trace_threshold at byte address 0
//
// one transaction per cycle while o_stall is low; stages in order: front, root, divide, output
// the root and divider pipelines set the latency; all stages advance together
// reset clears valid bits and trace_threshold
// o_stall rises only while a held result meets i_stall; the whole pipeline then freezes
`default_nettype none
module rotation_matrix_to_quaternion_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic signed [rmq_pkg::DATA_W-1:0] i_m00,
    input  wire logic signed [rmq_pkg::DATA_W-1:0] i_m01,
    input  wire logic signed [rmq_pkg::DATA_W-1:0] i_m02,
    input  wire logic signed [rmq_pkg::DATA_W-1:0] i_m10,
    input  wire logic signed [rmq_pkg::DATA_W-1:0] i_m11,
    input  wire logic signed [rmq_pkg::DATA_W-1:0] i_m12,
    input  wire logic signed [rmq_pkg::DATA_W-1:0] i_m20,
    input  wire logic signed [rmq_pkg::DATA_W-1:0] i_m21,
    input  wire logic signed [rmq_pkg::DATA_W-1:0] i_m22,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic signed [rmq_pkg::DATA_W-1:0]      o_quat_x,
    output logic signed [rmq_pkg::DATA_W-1:0]      o_quat_y,
    output logic signed [rmq_pkg::DATA_W-1:0]      o_quat_z,
    output logic signed [rmq_pkg::DATA_W-1:0]      o_quat_w,
    output logic                                   o_degenerate,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [2:0]                        paddr,
    input  wire logic [31:0]                       pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);
    import rmq_pkg::*;

    localparam logic REG_THR = 1'b0;

    logic                       en;
    logic [THR_W-1:0]           r_thr;
    logic                       f_valid;
    logic [SQ_IN_W-1:0]         f_rad;
    t_side                      f_side;
    logic                       s_valid;
    logic [S_W-1:0]             s_s;
    t_side                      s_side;
    logic                       d_valid;
    logic                       d_degen;
    logic [1:0]                 d_root;
    logic [S_W-2:0]             d_rval;
    logic [LANES-1:0][QUO_W-1:0] d_mag;
    logic [LANES-1:0]           d_neg;
    logic signed [DATA_W-1:0]   q0, q1, q2, qr;
    logic signed [DATA_W-1:0]   n_x, n_y, n_z, n_w;
    logic                       r_valid;
    logic signed [DATA_W-1:0]   r_x, r_y, r_z, r_w;
    logic                       r_degen;

    assign en      = !r_valid || !i_stall;
    assign o_stall = !en;
    assign pready  = 1'b1;
    assign prdata  = {{(32-THR_W){1'b0}}, r_thr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '0;
        end else if (psel && penable && pwrite && paddr[2] == REG_THR) begin
            r_thr <= pwdata[THR_W-1:0];
        end
    end

    rmq_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_m00   (i_m00),
        .i_m01   (i_m01),
        .i_m02   (i_m02),
        .i_m10   (i_m10),
        .i_m11   (i_m11),
        .i_m12   (i_m12),
        .i_m20   (i_m20),
        .i_m21   (i_m21),
        .i_m22   (i_m22),
        .i_thr   (r_thr),
        .o_valid (f_valid),
        .o_rad   (f_rad),
        .o_side  (f_side)
    );

    rmq_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_rad   (f_rad),
        .i_side  (f_side),
        .o_valid (s_valid),
        .o_s     (s_s),
        .o_side  (s_side)
    );

    rmq_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (s_valid),
        .i_s        (s_s),
        .i_side     (s_side),
        .o_valid    (d_valid),
        .o_degen    (d_degen),
        .o_root     (d_root),
        .o_root_val (d_rval),
        .o_mag      (d_mag),
        .o_neg      (d_neg)
    );

    always_comb begin
        q0 = sat_mag(d_mag[0], d_neg[0]);
        q1 = sat_mag(d_mag[1], d_neg[1]);
        q2 = sat_mag(d_mag[2], d_neg[2]);
        qr = $signed({1'b0, d_rval});
        case (d_root)
            ROOT_X: begin
                n_x = qr; n_w = q0; n_y = q1; n_z = q2;
            end
            ROOT_Y: begin
                n_y = qr; n_w = q0; n_z = q1; n_x = q2;
            end
            ROOT_Z: begin
                n_z = qr; n_w = q0; n_x = q1; n_y = q2;
            end
            default: begin
                n_w = qr; n_x = q0; n_y = q1; n_z = q2;
            end
        endcase
        if (d_degen) begin
            n_x = '0; n_y = '0; n_z = '0; n_w = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x     <= n_x;
            r_y     <= n_y;
            r_z     <= n_z;
            r_w     <= n_w;
            r_degen <= d_degen;
        end
    end

    assign o_valid      = r_valid;
    assign o_quat_x     = r_x;
    assign o_quat_y     = r_y;
    assign o_quat_z     = r_z;
    assign o_quat_w     = r_w;
    assign o_degenerate = r_degen;

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_quat_x == 0 && o_quat_y == 0 && o_quat_z == 0
                                    && o_quat_w == 0)
        else $error("degenerate result with nonzero components");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a blocked result");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");
endmodule
`default_nettype wire

// ===== design/rmq_front.sv =====
// input stage: trace test, branch choice, radicand and off-diagonal pair terms
// depends on rmq_pkg
`default_nettype none
module rmq_front (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_en,
    input  wire logic                            i_valid,
    input  wire logic signed [rmq_pkg::DATA_W-1:0] i_m00,
    input  wire logic signed [rmq_pkg::DATA_W-1:0] i_m01,
    input  wire logic signed [rmq_pkg::DATA_W-1:0] i_m02,
    input  wire logic signed [rmq_pkg::DATA_W-1:0] i_m10,
    input  wire logic signed [rmq_pkg::DATA_W-1:0] i_m11,
    input  wire logic signed [rmq_pkg::DATA_W-1:0] i_m12,
    input  wire logic signed [rmq_pkg::DATA_W-1:0] i_m20,
    input  wire logic signed [rmq_pkg::DATA_W-1:0] i_m21,
    input  wire logic signed [rmq_pkg::DATA_W-1:0] i_m22,
    input  wire logic [rmq_pkg::THR_W-1:0]       i_thr,
    output logic                                 o_valid,
    output logic [rmq_pkg::SQ_IN_W-1:0]          o_rad,
    output rmq_pkg::t_side                       o_side
);
    import rmq_pkg::*;

    logic signed [TRACE_W-1:0] trace;
    logic signed [RAD_W-1:0]   n_rad_s;
    logic [1:0]                pick;
    t_side                     n_side;
    logic                      r_valid;
    logic [SQ_IN_W-1:0]        r_rad;
    t_side                     r_side;

    localparam logic signed [RAD_W-1:0] ONE = RAD_W'(1) <<< FRAC_BITS;

    always_comb begin
        trace = TRACE_W'(i_m00) + TRACE_W'(i_m11) + TRACE_W'(i_m22);
        pick  = ROOT_X;
        if (i_m11 > i_m00) begin
            pick = ROOT_Y;
        end
        if ((pick == ROOT_X && i_m22 > i_m00) || (pick == ROOT_Y && i_m22 > i_m11)) begin
            pick = ROOT_Z;
        end
        if (trace > $signed({3'b000, i_thr})) begin
            pick = ROOT_W;
        end
        n_side.root = pick;
        case (pick)
            ROOT_X: begin
                n_rad_s   = RAD_W'(i_m00) - RAD_W'(i_m11) - RAD_W'(i_m22) + ONE;
                n_side.d0 = D_W'(i_m21) - D_W'(i_m12);
                n_side.d1 = D_W'(i_m10) + D_W'(i_m01);
                n_side.d2 = D_W'(i_m20) + D_W'(i_m02);
            end
            ROOT_Y: begin
                n_rad_s   = RAD_W'(i_m11) - RAD_W'(i_m22) - RAD_W'(i_m00) + ONE;
                n_side.d0 = D_W'(i_m02) - D_W'(i_m20);
                n_side.d1 = D_W'(i_m21) + D_W'(i_m12);
                n_side.d2 = D_W'(i_m01) + D_W'(i_m10);
            end
            ROOT_Z: begin
                n_rad_s   = RAD_W'(i_m22) - RAD_W'(i_m00) - RAD_W'(i_m11) + ONE;
                n_side.d0 = D_W'(i_m10) - D_W'(i_m01);
                n_side.d1 = D_W'(i_m02) + D_W'(i_m20);
                n_side.d2 = D_W'(i_m12) + D_W'(i_m21);
            end
            default: begin
                n_rad_s   = RAD_W'(trace) + ONE;
                n_side.d0 = D_W'(i_m21) - D_W'(i_m12);
                n_side.d1 = D_W'(i_m02) - D_W'(i_m20);
                n_side.d2 = D_W'(i_m10) - D_W'(i_m01);
            end
        endcase
        n_side.degen = (n_rad_s <= 0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= n_side;
            r_rad  <= n_side.degen ? '0
                    : SQ_IN_W'({n_rad_s[RAD_W-3:0], {FRAC_BITS{1'b0}}});
        end
    end

    assign o_valid = r_valid;
    assign o_rad   = r_rad;
    assign o_side  = r_side;
endmodule
`default_nettype wire

// ===== design/rmq_sqrt.sv =====
// pipelined integer square root, one result bit (one radicand bit pair) per stage
// depends on rmq_pkg
`default_nettype none
module rmq_sqrt (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_valid,
    input  wire logic [rmq_pkg::SQ_IN_W-1:0] i_rad,
    input  wire rmq_pkg::t_side             i_side,
    output logic                            o_valid,
    output logic [rmq_pkg::S_W-1:0]         o_s,
    output rmq_pkg::t_side                  o_side
);
    import rmq_pkg::*;

    logic                r_valid [1:SQ_STAGES];
    logic [SQ_IN_W-1:0]  r_rem   [1:SQ_STAGES];
    logic [SQ_RES_W-1:0] r_res   [1:SQ_STAGES];
    t_side               r_side  [1:SQ_STAGES];

    for (genvar n = 0; n < SQ_STAGES; n++) begin : g_stage
        localparam logic [SQ_RES_W-1:0] BIT = SQ_RES_W'(1) << (SQ_IN_W - 1 - 2 * n);
        logic                a_valid;
        logic [SQ_IN_W-1:0]  a_rem;
        logic [SQ_RES_W-1:0] a_res;
        t_side               a_side;
        logic [SQ_RES_W-1:0] trial;
        logic [SQ_IN_W-1:0]  n_rem;
        logic [SQ_RES_W-1:0] n_res;

        if (n == 0) begin : g_first
            assign a_valid = i_valid;
            assign a_rem   = i_rad;
            assign a_res   = '0;
            assign a_side  = i_side;
        end else begin : g_next
            assign a_valid = r_valid[n];
            assign a_rem   = r_rem[n];
            assign a_res   = r_res[n];
            assign a_side  = r_side[n];
        end

        always_comb begin
            trial = a_res + BIT;
            if ({1'b0, a_rem} >= trial) begin
                n_rem = a_rem - SQ_IN_W'(trial);
                n_res = (a_res >> 1) + BIT;
            end else begin
                n_rem = a_rem;
                n_res = a_res >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[n+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[n+1] <= a_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[n+1]  <= n_rem;
                r_res[n+1]  <= n_res;
                r_side[n+1] <= a_side;
            end
        end
    end

    assign o_valid = r_valid[SQ_STAGES];
    assign o_s     = r_res[SQ_STAGES][S_W-1:0];
    assign o_side  = r_side[SQ_STAGES];
endmodule
`default_nettype wire

// ===== design/rmq_div.sv =====
// three-lane pipelined restoring divider: (|d| << frac + s) / (2 s), one quotient bit per stage
// depends on rmq_pkg
`default_nettype none
module rmq_div (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_en,
    input  wire logic                                  i_valid,
    input  wire logic [rmq_pkg::S_W-1:0]               i_s,
    input  wire rmq_pkg::t_side                        i_side,
    output logic                                       o_valid,
    output logic                                       o_degen,
    output logic [1:0]                                 o_root,
    output logic [rmq_pkg::S_W-2:0]                    o_root_val,
    output logic [rmq_pkg::LANES-1:0][rmq_pkg::QUO_W-1:0] o_mag,
    output logic [rmq_pkg::LANES-1:0]                  o_neg
);
    import rmq_pkg::*;

    logic                              r_valid [0:QUO_W];
    logic                              r_degen [0:QUO_W];
    logic [1:0]                        r_root  [0:QUO_W];
    logic [S_W-2:0]                    r_rval  [0:QUO_W];
    logic [DEN_W-1:0]                  r_den   [0:QUO_W];
    logic [LANES-1:0]                  r_neg   [0:QUO_W];
    logic [LANES-1:0][NUM_W-1:0]       r_rem   [0:QUO_W];
    logic [LANES-1:0][QUO_W-1:0]       r_quo   [0:QUO_W];

    logic signed [D_W-1:0]        d_in [LANES];
    logic [LANES-1:0][NUM_W-1:0]  n_num;
    logic [LANES-1:0]             n_neg;

    always_comb begin
        d_in[0] = i_side.d0;
        d_in[1] = i_side.d1;
        d_in[2] = i_side.d2;
        for (int l = 0; l < LANES; l++) begin
            n_neg[l] = d_in[l][D_W-1];
            n_num[l] = ({{(NUM_W-D_W){1'b0}}, (n_neg[l] ? D_W'(-d_in[l]) : D_W'(d_in[l]))}
                        << FRAC_BITS) + NUM_W'(i_s);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_degen[0] <= i_side.degen;
            r_root[0]  <= i_side.root;
            r_rval[0]  <= i_s[S_W-1:1];
            r_den[0]   <= {i_s, 1'b0};
            r_neg[0]   <= n_neg;
            r_rem[0]   <= n_num;
            r_quo[0]   <= '0;
        end
    end

    for (genvar k = 1; k <= QUO_W; k++) begin : g_stage
        localparam int B = QUO_W - k;
        logic [LANES-1:0][NUM_W-1:0] n_rem;
        logic [LANES-1:0][QUO_W-1:0] n_quo;
        logic [CMP_W-1:0]            shd;

        always_comb begin
            shd = CMP_W'(r_den[k-1]) << B;
            for (int l = 0; l < LANES; l++) begin
                n_rem[l] = r_rem[k-1][l];
                n_quo[l] = r_quo[k-1][l];
                if (CMP_W'(r_rem[k-1][l]) >= shd) begin
                    n_rem[l]    = r_rem[k-1][l] - NUM_W'(shd);
                    n_quo[l][B] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= r_valid[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_degen[k] <= r_degen[k-1];
                r_root[k]  <= r_root[k-1];
                r_rval[k]  <= r_rval[k-1];
                r_den[k]   <= r_den[k-1];
                r_neg[k]   <= r_neg[k-1];
                r_rem[k]   <= n_rem;
                r_quo[k]   <= n_quo;
            end
        end
    end

    assign o_valid    = r_valid[QUO_W];
    assign o_degen    = r_degen[QUO_W];
    assign o_root     = r_root[QUO_W];
    assign o_root_val = r_rval[QUO_W];
    assign o_mag      = r_quo[QUO_W];
    assign o_neg      = r_neg[QUO_W];
endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
// testbench for rotation_matrix_to_quaternion_top: random and directed matrices,
// config writes over apb, results checked against a built-in predictor
// depends on rmq_pkg and the design files
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import rmq_pkg::*;

    localparam int ONE = 1 << FRAC_BITS;
    localparam logic [2:0] ADDR_THRESHOLD = 3'd0;
    localparam int LATENCY = 42;
    localparam longint CYCLE_LIMIT = 400000;

    typedef logic signed [DATA_W-1:0] t_elem;
    typedef struct packed {
        t_elem x, y, z, w;
        logic  degen;
    } t_quat;

    class quat_scoreboard;
        t_quat pending[$];
        int    errors;
        logic [THR_W-1:0] threshold;

        function automatic longint root64(longint v);
            longint r, b;
            r = 0;
            b = 64'sd1 << 62;
            while (b > v) b = b >>> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >>> 1) + b;
                end else begin
                    r = r >>> 1;
                end
                b = b >>> 2;
            end
            return r;
        endfunction

        function automatic longint rdiv(longint d, longint s);
            longint mag, q;
            mag = d < 0 ? -d : d;
            q = ((mag << FRAC_BITS) + s) / (2 * s);
            return d < 0 ? -q : q;
        endfunction

        function automatic t_elem clip(longint v);
            if (v > 32767) return 16'sh7fff;
            if (v < -32768) return 16'sh8000;
            return t_elem'(v);
        endfunction

        function void note_matrix(t_elem e[9]);
            longint m[3][3];
            longint q[4];
            longint tr, rad, s;
            int i, j, k;
            t_quat res;
            for (int n = 0; n < 9; n++) m[n / 3][n % 3] = e[n];
            q = '{0, 0, 0, 0};
            tr = m[0][0] + m[1][1] + m[2][2];
            res.degen = 1'b0;
            if (tr > longint'(threshold)) begin
                rad = tr + ONE;
                if (rad <= 0) begin
                    res.degen = 1'b1;
                end else begin
                    s = root64(rad << FRAC_BITS);
                    q[3] = s >>> 1;
                    q[0] = rdiv(m[2][1] - m[1][2], s);
                    q[1] = rdiv(m[0][2] - m[2][0], s);
                    q[2] = rdiv(m[1][0] - m[0][1], s);
                end
            end else begin
                i = 0;
                if (m[1][1] > m[0][0]) i = 1;
                if (m[2][2] > m[i][i]) i = 2;
                j = (i + 1) % 3;
                k = (j + 1) % 3;
                rad = m[i][i] - m[j][j] - m[k][k] + ONE;
                if (rad <= 0) begin
                    res.degen = 1'b1;
                end else begin
                    s = root64(rad << FRAC_BITS);
                    q[i] = s >>> 1;
                    q[3] = rdiv(m[k][j] - m[j][k], s);
                    q[j] = rdiv(m[j][i] + m[i][j], s);
                    q[k] = rdiv(m[k][i] + m[i][k], s);
                end
            end
            res.x = res.degen ? '0 : clip(q[0]);
            res.y = res.degen ? '0 : clip(q[1]);
            res.z = res.degen ? '0 : clip(q[2]);
            res.w = res.degen ? '0 : clip(q[3]);
            pending.push_back(res);
        endfunction

        function void check_quat(t_quat got);
            t_quat exp;
            if (pending.size() == 0) begin
                $display("%0t unexpected result x=%0d y=%0d z=%0d w=%0d deg=%0b",
                         $realtime, got.x, got.y, got.z, got.w, got.degen);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got !== exp) begin
                $display("%0t mismatch expected x=%0d y=%0d z=%0d w=%0d deg=%0b",
                         $realtime, exp.x, exp.y, exp.z, exp.w, exp.degen);
                $display("%0t          actual   x=%0d y=%0d z=%0d w=%0d deg=%0b",
                         $realtime, got.x, got.y, got.z, got.w, got.degen);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    t_elem mat[9];
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic o_stall, o_valid, o_degenerate, pready;
    t_elem o_quat_x, o_quat_y, o_quat_z, o_quat_w;
    logic [31:0] prdata;

    quat_scoreboard sb;
    longint cycles = 0;
    int idle_pct = 22;
    bit hold_off = 1'b0;

    initial for (int n = 0; n < 9; n++) mat[n] = '0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    rotation_matrix_to_quaternion_top dut (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_m00(mat[0]), .i_m01(mat[1]), .i_m02(mat[2]),
        .i_m10(mat[3]), .i_m11(mat[4]), .i_m12(mat[5]),
        .i_m20(mat[6]), .i_m21(mat[7]), .i_m22(mat[8]),
        .o_valid, .i_stall, .o_quat_x, .o_quat_y, .o_quat_z, .o_quat_w, .o_degenerate,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver side
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_quat('{o_quat_x, o_quat_y, o_quat_z, o_quat_w, o_degenerate});
        i_stall <= hold_off || ($urandom_range(99) < idle_pct);
    end

    task automatic write_threshold(input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_THRESHOLD; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        sb.threshold = val[THR_W-1:0];
    endtask

    task automatic send_matrix(input t_elem e[9]);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        for (int n = 0; n < 9; n++) mat[n] <= e[n];
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_matrix(e);
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    function automatic t_elem rand_elem();
        case ($urandom_range(5))
            0: return t_elem'($urandom);
            1: return t_elem'($urandom_range(ONE)) - t_elem'($urandom_range(ONE));
            2: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            default: return t_elem'($urandom_range(2 * ONE)) - t_elem'(ONE);
        endcase
    endfunction

    // random matrix: elements from rand_elem, mostly in [-1, 1] with some extremes; one in four fully random
    task automatic send_random(input int count);
        t_elem e[9];
        for (int c = 0; c < count; c++) begin
            for (int n = 0; n < 9; n++) e[n] = rand_elem();
            if ($urandom_range(3) == 0) begin
                for (int n = 0; n < 9; n++) e[n] = t_elem'($urandom);
            end
            send_matrix(e);
        end
    endtask

    task automatic send_directed;
        t_elem e[9];
        t_elem vals[4] = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'sh4000};
        e = '{16'sh4000, 0, 0, 0, 16'sh4000, 0, 0, 0, 16'sh4000};
        send_matrix(e);
        e = '{16'sh4000, 0, 0, 0, -16'sh4000, 0, 0, 0, -16'sh4000};
        send_matrix(e);
        e = '{-16'sh4000, 0, 0, 0, 16'sh4000, 0, 0, 0, -16'sh4000};
        send_matrix(e);
        e = '{-16'sh4000, 0, 0, 0, -16'sh4000, 0, 0, 0, 16'sh4000};
        send_matrix(e);
        e = '{16'sh2000, 0, 0, 0, 16'sh2000, 0, 0, 0, 16'sh2000};
        send_matrix(e);
        e = '{16'sh8000, 0, 0, 0, 16'sh8000, 0, 0, 0, 16'sh8000};
        send_matrix(e);
        e = '{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
              16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000};
        send_matrix(e);
        e = '{0, 16'sh8000, 16'sh7fff, 16'sh7fff, 0, 16'sh8000, 16'sh8000, 16'sh7fff, 0};
        send_matrix(e);
        e = '{-16'sh0001, 16'sh7fff, 16'sh7fff, 16'sh7fff, -16'sh0001,
              16'sh7fff, 16'sh7fff, 16'sh7fff, -16'sh0001};
        send_matrix(e);
        e = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
              16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff};
        send_matrix(e);
        e = '{-16'sh4000, 16'sh7fff, 16'sh8000, 16'sh8000, -16'sh4000,
              16'sh7fff, 16'sh7fff, 16'sh8000, -16'sh4000};
        send_matrix(e);
        for (int a = 0; a < 4; a++) begin
            for (int n = 0; n < 9; n++) e[n] = vals[(a + n) % 4];
            send_matrix(e);
        end
    endtask

    initial begin
        logic [31:0] settings[5] = '{32'h0000_4000, 32'h0000_0000, 32'hffff_8123,
                                     32'h0000_7fff, 32'h0000_2000};
        sb = new();
        sb.threshold = '0;
        sb.errors = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_directed();
        drain();
        foreach (settings[p]) begin
            write_threshold(settings[p]);
            send_directed();
            if (p == 1) begin
                idle_pct = 0;
                send_random(150);
                idle_pct = 22;
                hold_off = 1'b1;
                fork
                    begin
                        repeat (150) @(posedge i_clk);
                        hold_off = 1'b0;
                    end
                    send_random(100);
                join
            end
            send_random(260);
            drain();
        end
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
